### hdl/h264pps_pkg.sv
// Shared constants and types for the H.264 PPS field parser.
// No dependencies.
package h264pps_pkg;

    typedef logic [4:0] step_t;

    localparam step_t F_PPS     = 5'd0;
    localparam step_t F_SPS     = 5'd1;
    localparam step_t F_ENTROPY = 5'd2;
    localparam step_t F_BOTTOM  = 5'd3;
    localparam step_t F_NUMG    = 5'd4;
    localparam step_t F_MAPTYPE = 5'd5;
    localparam step_t F_RUN     = 5'd6;
    localparam step_t F_TL      = 5'd7;
    localparam step_t F_BR      = 5'd8;
    localparam step_t F_DIR     = 5'd9;
    localparam step_t F_RATE    = 5'd10;
    localparam step_t F_PICSIZE = 5'd11;
    localparam step_t F_GROUPID = 5'd12;
    localparam step_t F_REF0    = 5'd13;
    localparam step_t F_REF1    = 5'd14;
    localparam step_t F_WPRED   = 5'd15;
    localparam step_t F_BIP1    = 5'd16;
    localparam step_t F_BIP2    = 5'd17;
    localparam step_t F_QP      = 5'd18;
    localparam step_t F_QS      = 5'd19;
    localparam step_t F_CHROMA  = 5'd20;
    localparam step_t F_DEBLOCK = 5'd21;
    localparam step_t F_CONSTR  = 5'd22;
    localparam step_t F_REDUN   = 5'd23;
    localparam step_t F_DONE    = 5'd24;

    localparam logic [5:0] MAX_LEAD_ZEROS = 6'd31;

    // qp delta limits on the halved ue value
    localparam logic [30:0] QP_POS_HALF_MAX = 31'd24;
    localparam logic [30:0] QP_NEG_HALF_MAX = 31'd26;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_QP_RANGE  = 2'd2;

    localparam logic [2:0] MAP_RUNS    = 3'd0;
    localparam logic [2:0] MAP_RECTS   = 3'd2;
    localparam logic [2:0] MAP_EVO_LO  = 3'd3;
    localparam logic [2:0] MAP_EVO_HI  = 3'd5;
    localparam logic [2:0] MAP_EXPLICIT = 3'd6;

endpackage

### hdl/h264_pps_field_parser_unit.sv
// H.264 picture parameter set field parser, one payload bit per cycle while a byte is walked.
// Depends on h264pps_pkg.
//
// Payload bytes enter one item at a time on the s_ channel, the final byte
// marked by s_last_byte. Each accepted item passes through an accept step,
// a walk of its eight bits MSB first through the field sequencer and a
// finish step; a dropped emulation-prevention byte (0x03 after two zero
// bytes) goes straight from accept to finish. No new byte is taken before
// the finish step. On the final byte one result item is loaded into the m_
// output register and the parser returns to its reset state; the next byte
// is taken while that result still waits. ue(v)/se(v) codes are decoded
// serially in a shift accumulator, and the slice-group syntax is skipped for
// every map type. A status other than ok forces every other result field to zero.
module h264_pps_field_parser_unit (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_last_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic [31:0]        m_pps_id,
    output logic [31:0]        m_sps_id,
    output logic               m_entropy_mode,
    output logic               m_bottom_field_order,
    output logic               m_weighted_pred,
    output logic [1:0]         m_weighted_bipred,
    output logic signed [5:0]  m_init_qp_delta,
    output logic               m_redundant_cnt_present
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BITS = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // sequencer control
    logic [1:0]  state_reg, state_next;
    logic [2:0]  bit_cnt_reg, bit_cnt_next;
    logic [7:0]  shift_reg, shift_next;
    logic        last_reg, last_next;
    logic [1:0]  zero_run_reg, zero_run_next;

    // parser state
    h264pps_pkg::step_t step_reg, step_next;
    logic [5:0]  lead_reg, lead_next;
    logic [31:0] acc_reg, acc_next;
    logic        phase_reg, phase_next;
    logic [5:0]  len_reg, len_next;
    logic        nz_reg, nz_next;
    logic [31:0] group_reg, group_next;
    logic [5:0]  id_width_reg, id_width_next;
    logic [32:0] loop_reg, loop_next;
    logic [31:0] pps_reg, pps_next;
    logic [31:0] sps_reg, sps_next;
    logic [5:0]  flags_reg, flags_next;   // entropy, bottom, wpred, bipred[1:0], redun
    logic [5:0]  qp_reg, qp_next;
    logic [1:0]  status_reg, status_next;

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  o_status_reg;
    logic [31:0] o_pps_reg, o_sps_reg;
    logic [5:0]  o_flags_reg, o_qp_reg;
    logic        load_out;
    logic [1:0]  fin_status;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        logic        b;
        logic        do_done;
        logic        code_done;
        logic [31:0] v;
        logic [31:0] acc_sh;
        logic [5:0]  lead_inc;
        logic [31:0] cnt;
        logic [2:0]  kind;
        logic [30:0] half;

        state_next    = state_reg;
        bit_cnt_next  = bit_cnt_reg;
        shift_next    = shift_reg;
        last_next     = last_reg;
        zero_run_next = zero_run_reg;
        step_next     = step_reg;
        lead_next     = lead_reg;
        acc_next      = acc_reg;
        phase_next    = phase_reg;
        len_next      = len_reg;
        nz_next       = nz_reg;
        group_next    = group_reg;
        id_width_next = id_width_reg;
        loop_next     = loop_reg;
        pps_next      = pps_reg;
        sps_next      = sps_reg;
        flags_next    = flags_reg;
        qp_next       = qp_reg;
        status_next   = status_reg;
        load_out      = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;

        b         = shift_reg[7];
        do_done   = 1'b0;
        code_done = 1'b0;
        v         = 32'd0;
        acc_sh    = {acc_reg[30:0], b};
        lead_inc  = lead_reg + 6'd1;
        cnt       = acc_reg + 32'd1;
        kind      = 3'd0;
        half      = 31'd0;

        fin_status = (status_reg != h264pps_pkg::ST_OK) ? status_reg :
                     ((step_reg != h264pps_pkg::F_DONE) ? h264pps_pkg::ST_TRUNCATED
                                                         : h264pps_pkg::ST_OK);

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    last_next = s_last_byte;
                    if (zero_run_reg == 2'd2 && s_data_byte == 8'h03) begin
                        // drop the emulation-prevention byte
                        zero_run_next = 2'd0;
                        state_next    = S_FIN;
                    end else begin
                        if (s_data_byte == 8'h00)
                            zero_run_next = (zero_run_reg == 2'd2) ? 2'd2 : zero_run_reg + 2'd1;
                        else
                            zero_run_next = 2'd0;
                        shift_next   = s_data_byte;
                        bit_cnt_next = 3'd0;
                        state_next   = S_BITS;
                    end
                end
            end
            S_BITS: begin
                shift_next   = {shift_reg[6:0], 1'b0};
                bit_cnt_next = bit_cnt_reg + 3'd1;
                if (bit_cnt_reg == 3'd7)
                    state_next = S_FIN;

                if (status_reg == h264pps_pkg::ST_OK && step_reg != h264pps_pkg::F_DONE) begin
                    if (step_reg inside {h264pps_pkg::F_ENTROPY, h264pps_pkg::F_BOTTOM,
                                         h264pps_pkg::F_DIR, h264pps_pkg::F_GROUPID,
                                         h264pps_pkg::F_WPRED, h264pps_pkg::F_BIP1,
                                         h264pps_pkg::F_BIP2, h264pps_pkg::F_DEBLOCK,
                                         h264pps_pkg::F_CONSTR, h264pps_pkg::F_REDUN}) begin
                        do_done = 1'b1;
                        v       = {31'd0, b};
                    end else if (!phase_reg) begin
                        if (!b) begin
                            lead_next = lead_inc;
                            if (lead_inc > h264pps_pkg::MAX_LEAD_ZEROS) begin
                                status_next = h264pps_pkg::ST_TRUNCATED;
                                step_next   = h264pps_pkg::F_DONE;
                            end
                        end else if (lead_reg == 6'd0) begin
                            do_done = 1'b1;
                        end else begin
                            acc_next   = 32'd1;
                            phase_next = 1'b1;
                            len_next   = lead_reg;
                            nz_next    = 1'b0;
                        end
                    end else begin
                        acc_next  = acc_sh;
                        lead_next = lead_reg - 6'd1;
                        nz_next   = nz_reg | b;
                        if (lead_reg == 6'd1) begin
                            phase_next = 1'b0;
                            acc_next   = 32'd0;
                            do_done    = 1'b1;
                            code_done  = 1'b1;
                            v          = acc_sh - 32'd1;
                        end
                    end
                end

                if (do_done) begin
                    kind = (v > 32'd7) ? 3'd7 : v[2:0];
                    half = v[31:1];
                    case (step_reg)
                        h264pps_pkg::F_PPS:     begin pps_next = v; step_next = h264pps_pkg::F_SPS; end
                        h264pps_pkg::F_SPS:     begin sps_next = v; step_next = h264pps_pkg::F_ENTROPY; end
                        h264pps_pkg::F_ENTROPY: begin flags_next[0] = v[0]; step_next = h264pps_pkg::F_BOTTOM; end
                        h264pps_pkg::F_BOTTOM:  begin flags_next[1] = v[0]; step_next = h264pps_pkg::F_NUMG; end
                        h264pps_pkg::F_NUMG: begin
                            group_next = v;
                            // bit length of the value is the id width for map type 6
                            id_width_next = code_done ? len_reg + {5'd0, nz_reg | b} : 6'd0;
                            step_next = (v != 32'd0) ? h264pps_pkg::F_MAPTYPE : h264pps_pkg::F_REF0;
                        end
                        h264pps_pkg::F_MAPTYPE: begin
                            if (kind == h264pps_pkg::MAP_RUNS) begin
                                loop_next = {1'b0, group_reg} + 33'd1;
                                step_next = h264pps_pkg::F_RUN;
                            end else if (kind == h264pps_pkg::MAP_RECTS) begin
                                loop_next = {1'b0, group_reg};
                                step_next = h264pps_pkg::F_TL;
                            end else if (kind >= h264pps_pkg::MAP_EVO_LO &&
                                         kind <= h264pps_pkg::MAP_EVO_HI) begin
                                step_next = h264pps_pkg::F_DIR;
                            end else if (kind == h264pps_pkg::MAP_EXPLICIT) begin
                                step_next = h264pps_pkg::F_PICSIZE;
                            end else begin
                                step_next = h264pps_pkg::F_REF0;
                            end
                        end
                        h264pps_pkg::F_RUN: begin
                            loop_next = loop_reg - 33'd1;
                            if (loop_reg == 33'd1) step_next = h264pps_pkg::F_REF0;
                        end
                        h264pps_pkg::F_TL: step_next = h264pps_pkg::F_BR;
                        h264pps_pkg::F_BR: begin
                            loop_next = loop_reg - 33'd1;
                            step_next = (loop_reg == 33'd1) ? h264pps_pkg::F_REF0
                                                             : h264pps_pkg::F_TL;
                        end
                        h264pps_pkg::F_DIR:  step_next = h264pps_pkg::F_RATE;
                        h264pps_pkg::F_RATE: step_next = h264pps_pkg::F_REF0;
                        h264pps_pkg::F_PICSIZE: begin
                            loop_next = {1'b0, v} + 33'd1;
                            acc_next  = 32'd0;
                            step_next = h264pps_pkg::F_GROUPID;
                        end
                        h264pps_pkg::F_GROUPID: begin
                            acc_next = cnt;
                            if (cnt >= {26'd0, id_width_reg}) begin
                                acc_next  = 32'd0;
                                loop_next = loop_reg - 33'd1;
                                if (loop_reg == 33'd1) step_next = h264pps_pkg::F_REF0;
                            end
                        end
                        h264pps_pkg::F_REF0:  step_next = h264pps_pkg::F_REF1;
                        h264pps_pkg::F_REF1:  step_next = h264pps_pkg::F_WPRED;
                        h264pps_pkg::F_WPRED: begin flags_next[2] = v[0]; step_next = h264pps_pkg::F_BIP1; end
                        h264pps_pkg::F_BIP1:  begin flags_next[4] = v[0]; step_next = h264pps_pkg::F_BIP2; end
                        h264pps_pkg::F_BIP2:  begin flags_next[3] = v[0]; step_next = h264pps_pkg::F_QP; end
                        h264pps_pkg::F_QP: begin
                            if (v[0]) begin
                                if (half > h264pps_pkg::QP_POS_HALF_MAX) begin
                                    status_next = h264pps_pkg::ST_QP_RANGE;
                                    step_next   = h264pps_pkg::F_DONE;
                                end else begin
                                    qp_next   = half[5:0] + 6'd1;
                                    step_next = h264pps_pkg::F_QS;
                                end
                            end else begin
                                if (half > h264pps_pkg::QP_NEG_HALF_MAX) begin
                                    status_next = h264pps_pkg::ST_QP_RANGE;
                                    step_next   = h264pps_pkg::F_DONE;
                                end else begin
                                    qp_next   = 6'd0 - half[5:0];
                                    step_next = h264pps_pkg::F_QS;
                                end
                            end
                        end
                        h264pps_pkg::F_QS:      step_next = h264pps_pkg::F_CHROMA;
                        h264pps_pkg::F_CHROMA:  step_next = h264pps_pkg::F_DEBLOCK;
                        h264pps_pkg::F_DEBLOCK: step_next = h264pps_pkg::F_CONSTR;
                        h264pps_pkg::F_CONSTR:  step_next = h264pps_pkg::F_REDUN;
                        h264pps_pkg::F_REDUN:   begin flags_next[5] = v[0]; step_next = h264pps_pkg::F_DONE; end
                        default: step_next = h264pps_pkg::F_DONE;
                    endcase
                end
            end
            S_FIN: begin
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (!m_valid_reg || m_ready) begin
                    // hand off the result and start over for the next payload
                    load_out      = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = S_IDLE;
                    zero_run_next = 2'd0;
                    step_next     = h264pps_pkg::F_PPS;
                    lead_next     = 6'd0;
                    acc_next      = 32'd0;
                    phase_next    = 1'b0;
                    group_next    = 32'd0;
                    id_width_next = 6'd0;
                    loop_next     = 33'd0;
                    pps_next      = 32'd0;
                    sps_next      = 32'd0;
                    flags_next    = 6'd0;
                    qp_next       = 6'd0;
                    status_next   = h264pps_pkg::ST_OK;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            bit_cnt_reg  <= 3'd0;
            last_reg     <= 1'b0;
            zero_run_reg <= 2'd0;
            step_reg     <= h264pps_pkg::F_PPS;
            lead_reg     <= 6'd0;
            acc_reg      <= 32'd0;
            phase_reg    <= 1'b0;
            len_reg      <= 6'd0;
            nz_reg       <= 1'b0;
            group_reg    <= 32'd0;
            id_width_reg <= 6'd0;
            loop_reg     <= 33'd0;
            pps_reg      <= 32'd0;
            sps_reg      <= 32'd0;
            flags_reg    <= 6'd0;
            qp_reg       <= 6'd0;
            status_reg   <= h264pps_pkg::ST_OK;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            bit_cnt_reg  <= bit_cnt_next;
            last_reg     <= last_next;
            zero_run_reg <= zero_run_next;
            step_reg     <= step_next;
            lead_reg     <= lead_next;
            acc_reg      <= acc_next;
            phase_reg    <= phase_next;
            len_reg      <= len_next;
            nz_reg       <= nz_next;
            group_reg    <= group_next;
            id_width_reg <= id_width_next;
            loop_reg     <= loop_next;
            pps_reg      <= pps_next;
            sps_reg      <= sps_next;
            flags_reg    <= flags_next;
            qp_reg       <= qp_next;
            status_reg   <= status_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers: shift line and result fields
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        if (load_out) begin
            o_status_reg <= fin_status;
            if (fin_status == h264pps_pkg::ST_OK) begin
                o_pps_reg   <= pps_reg;
                o_sps_reg   <= sps_reg;
                o_flags_reg <= flags_reg;
                o_qp_reg    <= qp_reg;
            end else begin
                o_pps_reg   <= 32'd0;
                o_sps_reg   <= 32'd0;
                o_flags_reg <= 6'd0;
                o_qp_reg    <= 6'd0;
            end
        end
    end

    assign m_valid                 = m_valid_reg;
    assign m_status                = o_status_reg;
    assign m_pps_id                = o_pps_reg;
    assign m_sps_id                = o_sps_reg;
    assign m_entropy_mode          = o_flags_reg[0];
    assign m_bottom_field_order    = o_flags_reg[1];
    assign m_weighted_pred         = o_flags_reg[2];
    assign m_weighted_bipred       = o_flags_reg[4:3];
    assign m_init_qp_delta         = o_qp_reg;
    assign m_redundant_cnt_present = o_flags_reg[5];

endmodule

### sim/h264_pps_field_parser_checker.sv
// Checker for the PPS field parser: watches both channels, predicts each
// result from accepted payload bytes and compares field by field.
// Depends on h264pps_pkg.
module h264_pps_field_parser_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_last_byte,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [1:0]        m_status,
    input  logic [31:0]       m_pps_id,
    input  logic [31:0]       m_sps_id,
    input  logic              m_entropy_mode,
    input  logic              m_bottom_field_order,
    input  logic              m_weighted_pred,
    input  logic [1:0]        m_weighted_bipred,
    input  logic signed [5:0] m_init_qp_delta,
    input  logic              m_redundant_cnt_present,
    output int                fail_count,
    output int                pending_count,
    output int                result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] pps_id;
        logic [31:0] sps_id;
        logic        entropy;
        logic        bottom;
        logic        wpred;
        logic [1:0]  bipred;
        logic [5:0]  qp;
        logic        redun;
    } pps_result_t;

    pps_result_t pps_expected_q[$];

    logic [1:0]          zrun;
    h264pps_pkg::step_t  step;
    logic [5:0]          lzc;
    logic [31:0]         acc;
    logic                in_suffix;
    logic [31:0]         groups_m1;
    logic [2:0]          map_t;
    logic [5:0]          idw;
    logic [32:0]         remain;
    logic [31:0]         id_pps, id_sps;
    logic [15:0]         flags;
    logic [1:0]          pstat;

    function automatic logic is_flag_step(h264pps_pkg::step_t s);
        return s == h264pps_pkg::F_ENTROPY || s == h264pps_pkg::F_BOTTOM ||
               s == h264pps_pkg::F_DIR || s == h264pps_pkg::F_GROUPID ||
               s == h264pps_pkg::F_WPRED || s == h264pps_pkg::F_BIP1 ||
               s == h264pps_pkg::F_BIP2 || s == h264pps_pkg::F_DEBLOCK ||
               s == h264pps_pkg::F_CONSTR || s == h264pps_pkg::F_REDUN;
    endfunction

    task automatic parser_clear();
        zrun = 2'd0; step = h264pps_pkg::F_PPS; lzc = 6'd0; acc = 32'd0; in_suffix = 1'b0;
        groups_m1 = 32'd0; map_t = 3'd0; idw = 6'd0; remain = 33'd0;
        id_pps = 32'd0; id_sps = 32'd0; flags = 16'd0; pstat = h264pps_pkg::ST_OK;
    endtask

    task automatic finish_field(logic [31:0] v);
        logic [32:0] n;
        logic [5:0]  w;
        logic signed [31:0] q;
        case (step)
            h264pps_pkg::F_PPS: begin id_pps = v; step = h264pps_pkg::F_SPS; end
            h264pps_pkg::F_SPS: begin id_sps = v; step = h264pps_pkg::F_ENTROPY; end
            h264pps_pkg::F_ENTROPY: begin flags[0] = v[0]; step = h264pps_pkg::F_BOTTOM; end
            h264pps_pkg::F_BOTTOM: begin flags[1] = v[0]; step = h264pps_pkg::F_NUMG; end
            h264pps_pkg::F_NUMG: begin
                groups_m1 = v;
                step = (v > 32'd0) ? h264pps_pkg::F_MAPTYPE : h264pps_pkg::F_REF0;
            end
            h264pps_pkg::F_MAPTYPE: begin
                map_t = (v > 32'd7) ? 3'd7 : v[2:0];
                if (map_t == h264pps_pkg::MAP_RUNS) begin
                    remain = {1'b0, groups_m1} + 33'd1; step = h264pps_pkg::F_RUN;
                end else if (map_t == h264pps_pkg::MAP_RECTS) begin
                    remain = {1'b0, groups_m1}; step = h264pps_pkg::F_TL;
                end else if (map_t >= h264pps_pkg::MAP_EVO_LO &&
                             map_t <= h264pps_pkg::MAP_EVO_HI) begin
                    step = h264pps_pkg::F_DIR;
                end else if (map_t == h264pps_pkg::MAP_EXPLICIT) begin
                    step = h264pps_pkg::F_PICSIZE;
                end else begin
                    step = h264pps_pkg::F_REF0;
                end
            end
            h264pps_pkg::F_RUN: begin
                remain--;
                if (remain == 33'd0) step = h264pps_pkg::F_REF0;
            end
            h264pps_pkg::F_TL: step = h264pps_pkg::F_BR;
            h264pps_pkg::F_BR: begin
                remain--;
                step = (remain == 33'd0) ? h264pps_pkg::F_REF0 : h264pps_pkg::F_TL;
            end
            h264pps_pkg::F_DIR: step = h264pps_pkg::F_RATE;
            h264pps_pkg::F_RATE: step = h264pps_pkg::F_REF0;
            h264pps_pkg::F_PICSIZE: begin
                remain = {1'b0, v} + 33'd1;
                n = {1'b0, groups_m1} + 33'd1;
                w = 6'd0;
                while (w < 6'd40 && (33'd1 << w) < n) w++;
                idw = w; acc = 32'd0; step = h264pps_pkg::F_GROUPID;
            end
            h264pps_pkg::F_GROUPID: begin
                acc++;
                if (acc >= {26'd0, idw}) begin
                    acc = 32'd0; remain--;
                    if (remain == 33'd0) step = h264pps_pkg::F_REF0;
                end
            end
            h264pps_pkg::F_REF0: step = h264pps_pkg::F_REF1;
            h264pps_pkg::F_REF1: step = h264pps_pkg::F_WPRED;
            h264pps_pkg::F_WPRED: begin flags[2] = v[0]; step = h264pps_pkg::F_BIP1; end
            h264pps_pkg::F_BIP1: begin flags[4] = v[0]; step = h264pps_pkg::F_BIP2; end
            h264pps_pkg::F_BIP2: begin flags[3] = v[0]; step = h264pps_pkg::F_QP; end
            h264pps_pkg::F_QP: begin
                if (v[0] ? ((v >> 1) + 32'd1 > 32'd25) : ((v >> 1) > 32'd26)) begin
                    pstat = h264pps_pkg::ST_QP_RANGE; step = h264pps_pkg::F_DONE;
                end else begin
                    q = v[0] ? signed'((v >> 1) + 32'd1) : -signed'(v >> 1);
                    flags[13:8] = q[5:0]; step = h264pps_pkg::F_QS;
                end
            end
            h264pps_pkg::F_QS: step = h264pps_pkg::F_CHROMA;
            h264pps_pkg::F_CHROMA: step = h264pps_pkg::F_DEBLOCK;
            h264pps_pkg::F_DEBLOCK: step = h264pps_pkg::F_CONSTR;
            h264pps_pkg::F_CONSTR: step = h264pps_pkg::F_REDUN;
            h264pps_pkg::F_REDUN: begin flags[5] = v[0]; step = h264pps_pkg::F_DONE; end
            default: step = h264pps_pkg::F_DONE;
        endcase
    endtask

    task automatic walk_bit(logic b);
        if (pstat != h264pps_pkg::ST_OK || step >= h264pps_pkg::F_DONE) return;
        if (is_flag_step(step)) begin
            finish_field({31'd0, b});
        end else if (!in_suffix) begin
            if (!b) begin
                lzc++;
                if (lzc > h264pps_pkg::MAX_LEAD_ZEROS) begin
                    pstat = h264pps_pkg::ST_TRUNCATED; step = h264pps_pkg::F_DONE;
                end
            end else if (lzc == 6'd0) begin
                finish_field(32'd0);
            end else begin
                acc = 32'd1; in_suffix = 1'b1;
            end
        end else begin
            acc = {acc[30:0], b};
            lzc--;
            if (lzc == 6'd0) begin
                in_suffix = 1'b0;
                finish_field(acc - 32'd1);
                if (step != h264pps_pkg::F_GROUPID) acc = 32'd0;
            end
        end
    endtask

    // Advance the predictor by one payload byte; queue a result on the last one.
    task automatic take_byte(logic [7:0] by, logic last);
        pps_result_t r;
        if (zrun >= 2'd2 && by == 8'h03) begin
            zrun = 2'd0;
        end else begin
            zrun = (by == 8'h00) ? ((zrun >= 2'd2) ? 2'd2 : zrun + 2'd1) : 2'd0;
            for (int i = 7; i >= 0; i--) walk_bit(by[i]);
        end
        if (!last) return;
        r = '0;
        r.status = (pstat == h264pps_pkg::ST_OK && step != h264pps_pkg::F_DONE) ?
                   h264pps_pkg::ST_TRUNCATED : pstat;
        if (r.status == h264pps_pkg::ST_OK) begin
            r.pps_id = id_pps; r.sps_id = id_sps;
            r.entropy = flags[0]; r.bottom = flags[1]; r.wpred = flags[2];
            r.bipred = flags[4:3]; r.qp = flags[13:8]; r.redun = flags[5];
        end
        pps_expected_q.push_back(r);
        parser_clear();
    endtask

    task automatic cmp(string nm, logic [31:0] e, logic [31:0] a);
        if (e !== a) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $realtime, nm, e, a);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0; result_count = 0; pending_count = 0;
        parser_clear();
    end

    always @(posedge aclk) begin
        pps_result_t e;
        if (aresetn) begin
            if (s_valid && s_ready) take_byte(s_data_byte, s_last_byte);
            if (m_valid && m_ready) begin
                result_count++;
                if (pps_expected_q.size() == 0) begin
                    $display("%0t unexpected result item, status %0d", $realtime, m_status);
                    fail_count++;
                end else begin
                    e = pps_expected_q.pop_front();
                    cmp("status", {30'd0, e.status}, {30'd0, m_status});
                    cmp("pps_id", e.pps_id, m_pps_id);
                    cmp("sps_id", e.sps_id, m_sps_id);
                    cmp("entropy_mode", {31'd0, e.entropy}, {31'd0, m_entropy_mode});
                    cmp("bottom_field_order", {31'd0, e.bottom},
                        {31'd0, m_bottom_field_order});
                    cmp("weighted_pred", {31'd0, e.wpred}, {31'd0, m_weighted_pred});
                    cmp("weighted_bipred", {30'd0, e.bipred}, {30'd0, m_weighted_bipred});
                    // compare the raw six bits of the signed delta
                    cmp("init_qp_delta", {26'd0, e.qp}, {26'd0, m_init_qp_delta});
                    cmp("redundant_cnt_present", {31'd0, e.redun},
                        {31'd0, m_redundant_cnt_present});
                end
            end
            pending_count = pps_expected_q.size();
        end
    end
endmodule

### sim/tb_h264_pps_field_parser_unit.sv
// Top of the PPS field parser testbench: clock, reset, payload stimulus,
// receiver stalls, watchdog and verdict. Depends on h264pps_pkg and the checker.
module tb_h264_pps_field_parser_unit;
    timeunit 1ns;
    timeprecision 1ps;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_valid = 0;
    logic              s_ready;
    logic [7:0]        s_data_byte = 0;
    logic              s_last_byte = 0;
    logic              m_valid;
    logic              m_ready = 0;
    logic [1:0]        m_status;
    logic [31:0]       m_pps_id, m_sps_id;
    logic              m_entropy_mode, m_bottom_field_order, m_weighted_pred;
    logic [1:0]        m_weighted_bipred;
    logic signed [5:0] m_init_qp_delta;
    logic              m_redundant_cnt_present;
    int                fail_count, pending_count, result_count;

    // Idle percentages for the two sides; changed per phase by the stimulus.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_recv = 0;         // long receiver hold-off in progress
    int bytes_sent = 0;
    int quiet_cycles = 0;
    localparam int WATCHDOG_LIMIT = 20000;

    h264_pps_field_parser_unit u_top (.*);

    h264_pps_field_parser_checker u_chk (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
    end

    // Receiver: stall at the phase rate, or hold off entirely during the pressure stretch.
    always @(posedge aclk) begin
        if (!aresetn || hold_recv) begin
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (aresetn) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired after %0d quiet cycles", quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Bit writer used to build payloads; emulation bytes inserted on packing.
    bit payload_bits[$];

    task automatic put_bits(logic [63:0] v, int n);
        for (int i = n - 1; i >= 0; i--) payload_bits.push_back(v[i]);
    endtask

    task automatic put_ue(logic [31:0] v);
        logic [32:0] c;
        int n;
        c = {1'b0, v} + 33'd1;
        n = 0;
        while ((c >> (n + 1)) != 0) n++;
        put_bits(0, n);
        put_bits(c, n + 1);
    endtask

    task automatic put_se(int v);
        put_ue(v > 0 ? 2 * v - 1 : -2 * v);
    endtask

    // Send one item; maybe idle first, then hold valid until accepted.
    task automatic send_item(logic [7:0] by, logic last);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_data_byte <= by;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        bytes_sent++;
    endtask

    // Pack the bit buffer into bytes, inserting emulation prevention, and send.
    task automatic send_payload(bit with_stop, int extra);
        logic [7:0] bytes[$];
        logic [7:0] by;
        int zr;
        if (with_stop) payload_bits.push_back(1);
        while (payload_bits.size() % 8 != 0) payload_bits.push_back(0);
        zr = 0;
        while (payload_bits.size() > 0) begin
            by = 0;
            for (int i = 0; i < 8; i++) by = {by[6:0], logic'(payload_bits.pop_front())};
            if (zr >= 2 && by <= 8'h03) begin bytes.push_back(8'h03); zr = 0; end
            bytes.push_back(by);
            zr = (by == 0) ? zr + 1 : 0;
        end
        for (int i = 0; i < extra; i++) bytes.push_back($urandom_range(255));
        if (bytes.size() == 0) bytes.push_back($urandom_range(255));
        foreach (bytes[i]) send_item(bytes[i], i == bytes.size() - 1);
    endtask

    // Build a PPS; small sizes mostly, the map type and qp chosen by the caller.
    task automatic build_pps(logic [31:0] pps, logic [31:0] sps, int groups_m1,
                             int map_kind, int qp, bit trunc);
        int pic_m1;
        put_ue(pps); put_ue(sps);
        put_bits($urandom_range(1), 1); put_bits($urandom_range(1), 1);
        put_ue(groups_m1);
        if (groups_m1 > 0) begin
            put_ue(map_kind);
            case (map_kind)
                0: for (int i = 0; i <= groups_m1; i++) put_ue($urandom_range(20));
                2: for (int i = 0; i < groups_m1; i++) begin
                    put_ue($urandom_range(40)); put_ue($urandom_range(40));
                end
                3, 4, 5: begin put_bits($urandom_range(1), 1); put_ue($urandom_range(30)); end
                6: begin
                    pic_m1 = $urandom_range(6);
                    put_ue(pic_m1);
                    for (int i = 0; i <= pic_m1; i++) begin
                        int w = 0;
                        while ((1 << w) < groups_m1 + 1) w++;
                        put_bits($urandom, w);
                    end
                end
                default: ;
            endcase
        end
        put_ue($urandom_range(31)); put_ue($urandom_range(31));
        put_bits($urandom_range(1), 1); put_bits($urandom_range(3), 2);
        if (trunc) begin
            payload_bits = payload_bits[0:$urandom_range(payload_bits.size() - 1)];
            return;
        end
        put_se(qp); put_se($urandom_range(51) - 26); put_se($urandom_range(24) - 12);
        put_bits($urandom_range(7), 3);
    endtask

    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_count > 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    // One random payload: mostly well formed, some truncated or pure noise.
    task automatic random_payload();
        int pick, g, m;
        pick = $urandom_range(99);
        g = ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(3);
        m = $urandom_range(8);
        if (pick < 10) begin
            for (int i = $urandom_range(6); i > 0; i--) put_bits($urandom, 8);
            if ($urandom_range(1)) put_bits(0, 16);
            send_payload(0, 0);
        end else if (pick < 20) begin
            build_pps($urandom, $urandom_range(31), g, m, 0, 1);
            send_payload(0, 0);
        end else begin
            build_pps(($urandom_range(3) == 0) ? $urandom : $urandom_range(255),
                      $urandom_range(31), g, m,
                      (pick < 28) ? $urandom_range(80) - 40 : $urandom_range(51) - 26, 0);
            send_payload($urandom_range(1), $urandom_range(2));
        end
    endtask

    initial begin
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);

        // Directed: extreme ids, qp limits and both range errors, every map type.
        build_pps(0, 0, 0, 0, 0, 0);                 send_payload(1, 0);
        build_pps(32'hFFFF_FFFE, 32'hFFFF_FFFE, 0, 0, 25, 0); send_payload(1, 0);
        build_pps(1, 2, 0, 0, -26, 0);               send_payload(1, 0);
        build_pps(3, 4, 0, 0, 26, 0);                send_payload(1, 0);
        build_pps(5, 6, 0, 0, -27, 0);               send_payload(1, 0);
        for (int mk = 0; mk <= 8; mk++) begin
            build_pps(mk, 1, 3, mk, 5, 0);           send_payload(1, 1);
        end
        build_pps(7, 7, 1, 6, 0, 0);                 send_payload(1, 0);
        build_pps(8, 8, 0, 0, 0, 1);                 send_payload(0, 0); // truncation
        put_bits(0, 40);                             send_payload(0, 0); // long code, zeros
        send_item(8'hFF, 1);                         // lone byte
        send_item(8'h00, 0); send_item(8'h00, 0); send_item(8'h03, 1); // dropped final 0x03
        drain();

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 69 : (ph == 3) ? 34 : 0;
            recv_stall_pct = (ph == 2) ? 69 : (ph == 3) ? 34 : 0;
            while (bytes_sent < 40 + 165 * (ph + 1)) random_payload();
            if (ph == 1) drain(); // sender pauses until every result is back
        end

        // Pressure: receiver held off while payloads keep coming, input stalls.
        send_idle_pct = 0; recv_stall_pct = 0;
        fork
            begin
                hold_recv = 1;
                repeat (400) @(posedge aclk);
                hold_recv = 0;
            end
            repeat (6) random_payload();
        join
        drain();

        $display("covered %0d payload bytes, %0d results, all map types and idle phases",
                 bytes_sent, result_count);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
